// ----- rtl/lsdg_pkg.sv -----
// lsdg_pkg: shared types and constants for the led sparkle decay generator
// transaction payload structs, controller command/status structs, state enum
// no dependencies
`timescale 1ns / 1ps

package lsdg_pkg;

    localparam int PIXEL_COUNT_DEF       = 37;
    localparam int SPARKLES_PER_TICK_DEF = 3;

    localparam int PIX_W     = 6;
    localparam int HUE_W     = 9;
    localparam int LVL_W     = 8;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int SPK_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL      = 2'd1;

    localparam logic [CFG_W-1:0] UPDATE_INTERVAL_RST = 16'd30;
    localparam logic [LVL_W-1:0] PEAK_LEVEL_RST      = 8'd13;

    localparam int HUE_SECTOR = 60;
    localparam int HUE_SPAN   = 135;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [PIX_W-1:0]  spark0_index;
        logic [HUE_W-1:0]  spark0_hue;
        logic [PIX_W-1:0]  spark1_index;
        logic [HUE_W-1:0]  spark1_hue;
        logic [PIX_W-1:0]  spark2_index;
        logic [HUE_W-1:0]  spark2_hue;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_index;
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
        logic             frame_last;
    } t_out_item;

    typedef struct packed {
        logic [LVL_W-1:0] r;
        logic [LVL_W-1:0] g;
        logic [LVL_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic             accept;
        logic             hue_a;
        logic             hue_b;
        logic [SPK_W-1:0] spk_sel;
        logic             rd_en;
        logic [PIX_W-1:0] rd_idx;
    } t_cmd;

    typedef struct packed {
        logic upd_due;
        logic room;
        logic drained;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HUE_A,
        S_HUE_B,
        S_SWEEP,
        S_DRAIN
    } t_state;

endpackage

// ----- rtl/lsdg_ctrl.sv -----
// lsdg_ctrl: sequencer for one tick: accept, sparkle color steps, pixel sweep, drain
// drives command struct to lsdg_datapath, reads its status struct
// depends on lsdg_pkg
`timescale 1ns / 1ps

module lsdg_ctrl
    import lsdg_pkg::*;
#(
    parameter int PIXEL_COUNT       = PIXEL_COUNT_DEF,
    parameter int SPARKLES_PER_TICK = SPARKLES_PER_TICK_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [SPK_W-1:0] r_spk, n_spk;
    logic [PIX_W-1:0] r_rd_idx, n_rd_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_spk    <= '0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_spk    <= n_spk;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_spk          = r_spk;
        n_rd_idx       = r_rd_idx;
        o_in_stall     = 1'b1;
        o_cmd          = '0;
        o_cmd.spk_sel  = r_spk;
        o_cmd.rd_idx   = r_rd_idx;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_spk        = '0;
                    n_rd_idx     = '0;
                    n_state      = i_sts.upd_due ? S_HUE_A : S_SWEEP;
                end
            end
            S_HUE_A: begin
                o_cmd.hue_a = 1'b1;
                n_state     = S_HUE_B;
            end
            S_HUE_B: begin
                o_cmd.hue_b = 1'b1;
                if (r_spk == SPK_W'(SPARKLES_PER_TICK - 1)) begin
                    n_state = S_SWEEP;
                end else begin
                    n_spk   = r_spk + 1'b1;
                    n_state = S_HUE_A;
                end
            end
            S_SWEEP: begin
                if (i_sts.room) begin
                    o_cmd.rd_en = 1'b1;
                    if (r_rd_idx == PIX_W'(PIXEL_COUNT - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (i_sts.drained) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lsdg_datapath.sv -----
// lsdg_datapath: config registers, sparkle color unit, pixel store and output stage
// pixel store is a one-write one-read memory with per-entry valid bits
// depends on lsdg_pkg
`timescale 1ns / 1ps

module lsdg_datapath
    import lsdg_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    // configuration and tick state
    logic [CFG_W-1:0]  r_interval;
    logic [LVL_W-1:0]  r_peak;
    logic [TIME_W-1:0] r_last;
    logic              r_upd;
    t_in_item          r_item;

    // sparkle colors
    logic [3:0]        r_region;
    logic [LVL_W-1:0]  r_rem;
    t_rgb              r_sp_rgb [3];
    logic [2:0]        r_sp_en;

    // pixel store
    t_rgb              r_mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] r_vld;
    t_rgb              r_rdata;
    logic              r_rvld;
    logic              r_pend;
    logic [PIX_W-1:0]  r_pidx;

    // output stage with skid
    logic              r_ov;
    t_out_item         r_out;
    logic              r_hold_v;
    t_out_item         r_hold;

    logic [TIME_W-1:0] elapsed;
    logic [HUE_W-1:0]  sel_hue;
    logic [PIX_W-1:0]  sel_idx;
    logic [3:0]        region;
    logic [9:0]        region_deg;
    logic [5:0]        rem_deg;
    logic [9:0]        rem_x9;
    logic [15:0]       q_prod;
    logic [15:0]       t_prod;
    logic [LVL_W-1:0]  q_lvl;
    logic [LVL_W-1:0]  t_lvl;
    t_rgb              hue_rgb;
    t_rgb              base;
    t_rgb              nv;
    t_out_item         land;
    logic              take;
    logic              out_free;
    logic [1:0]        occ;
    logic [PIX_W-1:0]  sp_idx [3];

    assign elapsed         = i_in_data.time_ms - r_last;
    assign o_sts.upd_due   = elapsed >= TIME_W'(r_interval);
    assign take            = r_ov && !i_out_stall;
    assign out_free        = !r_ov || !i_out_stall;
    assign occ             = 2'(r_ov) + 2'(r_hold_v) + 2'(r_pend);
    assign o_sts.room      = (occ - 2'(take)) <= 2'd1;
    assign o_sts.drained   = !r_pend && !r_ov && !r_hold_v;
    assign o_out_valid     = r_ov;
    assign o_out_data      = r_out;

    assign sp_idx[0] = r_item.spark0_index;
    assign sp_idx[1] = r_item.spark1_index;
    assign sp_idx[2] = r_item.spark2_index;

    always_comb begin
        case (i_cmd.spk_sel)
            2'd0:    begin sel_hue = r_item.spark0_hue; sel_idx = r_item.spark0_index; end
            2'd1:    begin sel_hue = r_item.spark1_hue; sel_idx = r_item.spark1_index; end
            default: begin sel_hue = r_item.spark2_hue; sel_idx = r_item.spark2_index; end
        endcase
    end

    // hue region and scaled remainder
    always_comb begin
        region = '0;
        for (int j = 1; j <= 8; j++) begin
            region = region + 4'(sel_hue >= HUE_W'(HUE_SECTOR * j));
        end
        region_deg = 10'(region) * 10'(HUE_SECTOR);
        rem_deg    = 6'(10'(sel_hue) - region_deg);
        // 135/60 reduces to 9/4
        rem_x9     = 10'(rem_deg) * 10'd9;
    end

    always_comb begin
        q_prod = 16'(r_peak) * 16'(LVL_W'(HUE_SPAN) - r_rem);
        t_prod = 16'(r_peak) * 16'(r_rem);
        q_lvl  = q_prod[15:8];
        t_lvl  = t_prod[15:8];
        case (r_region)
            4'd0:    hue_rgb = '{r: r_peak, g: t_lvl,  b: '0};
            4'd1:    hue_rgb = '{r: q_lvl,  g: r_peak, b: '0};
            4'd2:    hue_rgb = '{r: '0,     g: r_peak, b: t_lvl};
            4'd3:    hue_rgb = '{r: '0,     g: q_lvl,  b: r_peak};
            4'd4:    hue_rgb = '{r: t_lvl,  g: '0,     b: r_peak};
            default: hue_rgb = '{r: r_peak, g: '0,     b: q_lvl};
        endcase
    end

    // new pixel value at landing
    always_comb begin
        base = r_rvld ? r_rdata : '0;
        nv   = base;
        if (r_upd) begin
            nv.r = (base.r == '0) ? '0 : base.r - 1'b1;
            nv.g = (base.g == '0) ? '0 : base.g - 1'b1;
            nv.b = (base.b == '0) ? '0 : base.b - 1'b1;
            for (int k = 0; k < 3; k++) begin
                if (r_sp_en[k] && sp_idx[k] == r_pidx) begin
                    nv = r_sp_rgb[k];
                end
            end
        end
        land.pixel_index = r_pidx;
        land.red_level   = nv.r;
        land.green_level = nv.g;
        land.blue_level  = nv.b;
        land.frame_last  = r_pidx == PIX_W'(PIXEL_COUNT - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= UPDATE_INTERVAL_RST;
            r_peak     <= PEAK_LEVEL_RST;
            r_last     <= '0;
            r_upd      <= 1'b0;
            r_sp_en    <= '0;
            r_vld      <= '0;
            r_pend     <= 1'b0;
            r_ov       <= 1'b0;
            r_hold_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UPDATE_INTERVAL: r_interval <= i_cfg_data;
                    CFG_PEAK_LEVEL:      r_peak     <= i_cfg_data[LVL_W-1:0];
                    default:             ;
                endcase
            end
            if (i_cmd.accept) begin
                r_upd   <= o_sts.upd_due;
                r_sp_en <= '0;
                if (o_sts.upd_due) begin
                    r_last <= i_in_data.time_ms;
                end
            end
            if (i_cmd.hue_b) begin
                for (int k = 0; k < 3; k++) begin
                    if (i_cmd.spk_sel == SPK_W'(k)) begin
                        r_sp_en[k] <= 7'(sel_idx) < 7'(PIXEL_COUNT);
                    end
                end
            end
            r_pend <= i_cmd.rd_en;
            if (r_pend && r_upd) begin
                r_vld[r_pidx[AW-1:0]] <= 1'b1;
            end
            if (out_free) begin
                if (r_hold_v) begin
                    r_ov     <= 1'b1;
                    r_hold_v <= r_pend;
                end else begin
                    r_ov <= r_pend;
                end
            end else if (r_pend) begin
                r_hold_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.hue_a) begin
            r_region <= region;
            r_rem    <= rem_x9[9:2];
        end
        if (i_cmd.hue_b) begin
            for (int k = 0; k < 3; k++) begin
                if (i_cmd.spk_sel == SPK_W'(k)) begin
                    r_sp_rgb[k] <= hue_rgb;
                end
            end
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.rd_idx[AW-1:0]];
            r_rvld  <= r_vld[i_cmd.rd_idx[AW-1:0]];
            r_pidx  <= i_cmd.rd_idx;
        end
        if (r_pend && r_upd) begin
            r_mem[r_pidx[AW-1:0]] <= nv;
        end
        if (out_free) begin
            if (r_hold_v) begin
                r_out <= r_hold;
                if (r_pend) begin
                    r_hold <= land;
                end
            end else if (r_pend) begin
                r_out <= land;
            end
        end else if (r_pend) begin
            r_hold <= land;
        end
    end

endmodule

// ----- rtl/led_sparkle_decay_generator_unit.sv -----
// Each accepted tick transaction yields PIXEL_COUNT pixel transactions in index order, the last
// flagged with frame_last. A tick that falls within the update interval resends the stored frame;
// an update tick first takes each sparkle in turn through the shared hue-to-color unit (one step
// for region and remainder, one for the two 8x8 products), then fades and paints during the
// sweep. The sweep reads the pixel store once per cycle through its single read port while the
// output stage has room, so output stalls stretch it. No clearing pass is needed after reset:
// per-pixel valid bits make unwritten pixels read as zero. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
// top level: lsdg_ctrl sequencer and lsdg_datapath, depends on lsdg_pkg
`timescale 1ns / 1ps

module led_sparkle_decay_generator_unit
    import lsdg_pkg::*;
#(
    parameter int PIXEL_COUNT       = PIXEL_COUNT_DEF,
    parameter int SPARKLES_PER_TICK = SPARKLES_PER_TICK_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    t_cmd cmd;
    t_sts sts;

    lsdg_ctrl #(
        .PIXEL_COUNT       (PIXEL_COUNT),
        .SPARKLES_PER_TICK (SPARKLES_PER_TICK)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lsdg_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- dv/testbench.sv -----
// testbench for led_sparkle_decay_generator_unit: sends tick transactions and checks every
// pixel transaction against an in-bench model of the fade, sparkle paint and hue-to-color rule
// depends on lsdg_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;
    import lsdg_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned SETTLE_CYCLES  = 64;
    localparam int unsigned RX_HOLD_CYCLES = 600;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;

    // model state
    logic [LVL_W-1:0]  red_lvl   [PIXEL_COUNT_DEF];
    logic [LVL_W-1:0]  green_lvl [PIXEL_COUNT_DEF];
    logic [LVL_W-1:0]  blue_lvl  [PIXEL_COUNT_DEF];
    logic [TIME_W-1:0] last_update_ms = '0;
    logic [CFG_W-1:0]  update_interval = UPDATE_INTERVAL_RST;
    logic [LVL_W-1:0]  peak_level = PEAK_LEVEL_RST;

    t_out_item         frame_pixels_q[$];
    logic [TIME_W-1:0] tick_clock_ms = '0;
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_idle_pct = 0;
    logic              rx_hold_req = 1'b0;
    int unsigned       rx_hold_left = 0;
    int unsigned       cycle_count = 0;
    int unsigned       mismatches = 0;

    led_sparkle_decay_generator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < PIXEL_COUNT_DEF; i++) begin
            red_lvl[i]   = '0;
            green_lvl[i] = '0;
            blue_lvl[i]  = '0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: long hold-off on request, else random stall
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic t_rgb hue_to_rgb(input logic [HUE_W-1:0] hue,
                                        input logic [LVL_W-1:0] peak);
        int unsigned p, region, rem, q, t;
        t_rgb c;
        p      = 32'(peak);
        region = 32'(hue) / HUE_SECTOR;
        rem    = (32'(hue) - region * HUE_SECTOR) * HUE_SPAN / HUE_SECTOR;
        q      = (p * (HUE_SPAN - rem)) >> 8;
        t      = (p * rem) >> 8;
        case (region)
            0: begin
                c.r = LVL_W'(p); c.g = LVL_W'(t); c.b = '0;
            end
            1: begin
                c.r = LVL_W'(q); c.g = LVL_W'(p); c.b = '0;
            end
            2: begin
                c.r = '0; c.g = LVL_W'(p); c.b = LVL_W'(t);
            end
            3: begin
                c.r = '0; c.g = LVL_W'(q); c.b = LVL_W'(p);
            end
            4: begin
                c.r = LVL_W'(t); c.g = '0; c.b = LVL_W'(p);
            end
            default: begin
                c.r = LVL_W'(p); c.g = '0; c.b = LVL_W'(q);
            end
        endcase
        return c;
    endfunction

    // advance the model by one tick and queue the frame it sends
    function automatic void tick_to_frame(input t_in_item item);
        logic [PIX_W-1:0]  spark_idx [3];
        logic [HUE_W-1:0]  spark_hue [3];
        logic [TIME_W-1:0] elapsed;
        t_rgb              c;
        t_out_item         px;
        spark_idx = '{item.spark0_index, item.spark1_index, item.spark2_index};
        spark_hue = '{item.spark0_hue, item.spark1_hue, item.spark2_hue};
        elapsed   = item.time_ms - last_update_ms;
        if (elapsed >= TIME_W'(update_interval)) begin
            last_update_ms = item.time_ms;
            for (int i = 0; i < PIXEL_COUNT_DEF; i++) begin
                red_lvl[i]   = (red_lvl[i] > 1)   ? red_lvl[i] - 1'b1   : '0;
                green_lvl[i] = (green_lvl[i] > 1) ? green_lvl[i] - 1'b1 : '0;
                blue_lvl[i]  = (blue_lvl[i] > 1)  ? blue_lvl[i] - 1'b1  : '0;
            end
            for (int n = 0; n < SPARKLES_PER_TICK_DEF && n < 3; n++) begin
                if (spark_idx[n] < PIXEL_COUNT_DEF) begin
                    c = hue_to_rgb(spark_hue[n], peak_level);
                    red_lvl[spark_idx[n]]   = c.r;
                    green_lvl[spark_idx[n]] = c.g;
                    blue_lvl[spark_idx[n]]  = c.b;
                end
            end
        end
        for (int i = 0; i < PIXEL_COUNT_DEF; i++) begin
            px.pixel_index = PIX_W'(i);
            px.red_level   = red_lvl[i];
            px.green_level = green_lvl[i];
            px.blue_level  = blue_lvl[i];
            px.frame_last  = (i == PIXEL_COUNT_DEF - 1);
            frame_pixels_q.push_back(px);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : pixel_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_pixels_q.size() == 0) begin
                $error("pixel transaction with none expected: %p", o_out_data);
                mismatches++;
            end else begin
                want = frame_pixels_q.pop_front();
                check_field("pixel_index", 32'(want.pixel_index),
                            32'(o_out_data.pixel_index));
                check_field("red_level", 32'(want.red_level), 32'(o_out_data.red_level));
                check_field("green_level", 32'(want.green_level),
                            32'(o_out_data.green_level));
                check_field("blue_level", 32'(want.blue_level), 32'(o_out_data.blue_level));
                check_field("frame_last", 32'(want.frame_last), 32'(o_out_data.frame_last));
            end
        end
    end

    // called at a clock edge, returns at the edge where the tick was accepted
    task automatic send_tick(input t_in_item item);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tick_to_frame(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (frame_pixels_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_UPDATE_INTERVAL: update_interval = data;
            CFG_PEAK_LEVEL:      peak_level = data[LVL_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_in_item make_tick(input logic [TIME_W-1:0] t_ms,
                                           input int i0, input int h0,
                                           input int i1, input int h1,
                                           input int i2, input int h2);
        t_in_item item;
        item.time_ms      = t_ms;
        item.spark0_index = PIX_W'(i0);
        item.spark0_hue   = HUE_W'(h0);
        item.spark1_index = PIX_W'(i1);
        item.spark1_hue   = HUE_W'(h1);
        item.spark2_index = PIX_W'(i2);
        item.spark2_hue   = HUE_W'(h2);
        return item;
    endfunction

    function automatic int rand_index();
        if ($urandom_range(99) < 88) return $urandom_range(PIXEL_COUNT_DEF - 1);
        return $urandom_range(63, PIXEL_COUNT_DEF);
    endfunction

    function automatic int rand_hue();
        if ($urandom_range(99) < 85) return $urandom_range(359);
        return $urandom_range(511, 360);
    endfunction

    // times mostly step around the interval, with some far jumps and steps back
    function automatic t_in_item rand_tick();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            tick_clock_ms += $urandom_range(32'(update_interval));
        else if (pick < 80)
            tick_clock_ms += 32'(update_interval) + $urandom_range(32'(update_interval));
        else if (pick < 90)
            tick_clock_ms = $urandom();
        else
            tick_clock_ms -= $urandom_range(50);
        return make_tick(tick_clock_ms, rand_index(), rand_hue(), rand_index(), rand_hue(),
                         rand_index(), rand_hue());
    endfunction

    task automatic test_interval_after_reset();
        send_tick(make_tick(32'd0, 3, 10, 4, 100, 5, 200));
        send_tick(make_tick(32'd29, 3, 10, 4, 100, 5, 200));
        send_tick(make_tick(32'd30, 3, 10, 4, 100, 5, 200));
        wait_drained();
    endtask

    task automatic test_hue_regions();
        write_reg(CFG_UPDATE_INTERVAL, 16'd0);
        write_reg(CFG_PEAK_LEVEL, 16'hA5FF);
        send_tick(make_tick(32'd100, 0, 0, 1, 59, 2, 60));
        send_tick(make_tick(32'd100, 3, 119, 4, 120, 5, 179));
        send_tick(make_tick(32'd101, 6, 180, 7, 239, 8, 240));
        send_tick(make_tick(32'd101, 9, 299, 10, 300, 36, 359));
        send_tick(make_tick(32'd102, 11, 360, 12, 511, 13, 420));
        // indices past the last pixel are dropped
        send_tick(make_tick(32'd103, 37, 30, 63, 90, 36, 150));
        wait_drained();
    endtask

    task automatic test_sparkle_overwrite();
        send_tick(make_tick(32'd200, 20, 30, 20, 150, 20, 270));
        send_tick(make_tick(32'd200, 21, 45, 22, 45, 21, 330));
        wait_drained();
        write_reg(CFG_PEAK_LEVEL, 16'd0);
        send_tick(make_tick(32'd201, 20, 200, 0, 45, 36, 500));
        wait_drained();
    endtask

    task automatic test_unused_registers();
        write_reg(CFG_IDX_SPARE_A, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_B, 16'hFFFF);
        send_tick(make_tick(32'd300, 1, 45, 2, 165, 3, 285));
        wait_drained();
    endtask

    task automatic test_time_wrap();
        write_reg(CFG_UPDATE_INTERVAL, 16'd30);
        write_reg(CFG_PEAK_LEVEL, 16'd255);
        send_tick(make_tick(32'hFFFF_FFF0, 14, 15, 15, 75, 16, 135));
        send_tick(make_tick(32'h0000_0005, 17, 195, 18, 255, 19, 315));
        send_tick(make_tick(32'h0000_0020, 17, 195, 18, 255, 19, 315));
        send_tick(make_tick(32'h0000_0010, 23, 5, 24, 65, 25, 125));
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        tick_clock_ms = last_update_ms;
        rx_hold_req = 1'b1;
        repeat (8) send_tick(rand_tick());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        tick_clock_ms = last_update_ms;
        repeat (count) send_tick(rand_tick());
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_interval_after_reset();
        test_hue_regions();
        test_sparkle_overwrite();
        test_unused_registers();
        test_time_wrap();
        test_backpressure();

        write_reg(CFG_PEAK_LEVEL, 16'd200);
        test_random_traffic(125, 27, 53);
        write_reg(CFG_UPDATE_INTERVAL, 16'hFFFF);
        write_reg(CFG_PEAK_LEVEL, CFG_W'($urandom_range(65535)));
        test_random_traffic(125, 53, 27);
        write_reg(CFG_UPDATE_INTERVAL, CFG_W'($urandom_range(100, 1)));
        write_reg(CFG_PEAK_LEVEL, 16'd255);
        test_random_traffic(125, 0, 0);

        if (frame_pixels_q.size() != 0) begin
            $error("%0d pixel transactions never arrived", frame_pixels_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
